[rtl/core/int_to_decimal_ascii_assert.svh]
// ---------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define I2DA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("int_to_decimal_ascii check failed");

// next-cycle implication
`define I2DA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("int_to_decimal_ascii check failed");

`endif

[rtl/core/i2da_pkg.sv]
// ---------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ---------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CHAR_BITS          = 6;
   localparam int BITS_PER_STEP      = 4;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

   typedef struct packed {
      logic load;
      logic step;
      logic find;
      logic next_digit;
      logic sel_sign;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_step;
      logic neg;
      logic last_digit;
   } dp_status_type;

endpackage

[rtl/core/i2da_if.sv]
// ---------------------------------------------------------------------------
// i2da interfaces
// Valid/ready channels for the request value and the response character.
// ---------------------------------------------------------------------------
interface i2da_req_if #(
   parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface i2da_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [i2da_pkg::CHAR_BITS-1:0]   char_code;
   logic                             last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

[rtl/core/i2da_ctrl.sv]
// ---------------------------------------------------------------------------
// i2da_ctrl
// Sequencer: load, BCD conversion steps, leading digit scan, emission.
// ---------------------------------------------------------------------------
module i2da_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  i2da_pkg::dp_status_type status,
   output i2da_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_FIND  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = status.neg ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_digit = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/i2da_dp.sv]
// ---------------------------------------------------------------------------
// i2da_dp
// Magnitude, shift-and-add-3 BCD conversion four bits a step, digit select.
// ---------------------------------------------------------------------------
module i2da_dp #(
   parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [VALUE_BITS-1:0]            value,
   input  i2da_pkg::ctrl_cmd_type           cmd,
   output i2da_pkg::dp_status_type          status,
   output logic [i2da_pkg::CHAR_BITS-1:0]   char_code,
   output logic                             last
);

   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int STEP_BITS  = i2da_pkg::BITS_PER_STEP;
   localparam int PAD_BITS   = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int STEPS      = PAD_BITS / STEP_BITS;
   localparam int STEP_W     = $clog2(STEPS + 1);
   localparam int IDX_W      = $clog2(NUM_DIGITS);

   logic                  neg_ff;
   logic [PAD_BITS-1:0]   sh_ff;
   logic [PAD_BITS-1:0]   sh_in;
   logic [3:0]            bcd_ff [NUM_DIGITS];
   logic [3:0]            bcd_in [NUM_DIGITS];
   logic [STEP_W-1:0]     step_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      lead;
   logic [VALUE_BITS-1:0] mag;
   logic [3:0]            digit;

   assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

   // shift-and-add-3, one bit per pass
   always_comb begin
      sh_in  = sh_ff;
      bcd_in = bcd_ff;
      for (int b = 0; b < STEP_BITS; b++) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_in[i] >= 4'd5) begin
               bcd_in[i] = bcd_in[i] + 4'd3;
            end
         end
         for (int i = NUM_DIGITS - 1; i > 0; i--) begin
            bcd_in[i] = {bcd_in[i][2:0], bcd_in[i-1][3]};
         end
         bcd_in[0] = {bcd_in[0][2:0], sh_in[PAD_BITS-1]};
         sh_in     = {sh_in[PAD_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      lead = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            lead = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= STEP_W'(STEPS);
      end else if (cmd.step) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= value[VALUE_BITS-1];
         sh_ff  <= PAD_BITS'(mag);
         for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_ff[i] <= 4'd0;
         end
      end else if (cmd.step) begin
         sh_ff  <= sh_in;
         bcd_ff <= bcd_in;
      end
      if (cmd.find) begin
         idx_ff <= lead;
      end else if (cmd.next_digit) begin
         idx_ff <= idx_ff - IDX_W'(1);
      end
   end

   assign digit             = bcd_ff[idx_ff];
   assign status.last_step  = (step_ff == STEP_W'(1));
   assign status.neg        = neg_ff;
   assign status.last_digit = (idx_ff == '0);
   assign char_code = cmd.sel_sign ? i2da_pkg::CHAR_MINUS
                                   : (i2da_pkg::CHAR_ZERO + {2'b00, digit});
   assign last      = !cmd.sel_sign && (idx_ff == '0);

endmodule

[rtl/core/int_to_decimal_ascii.sv]
// ---------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per response word.
//
// req_ch carries one signed value per word; rsp_ch returns its text most
// significant character first, '-' leading for negative values, no
// leading zeros, last set on the final character.
// One value is handled at a time: req_ch.ready is high only when idle.
// After acceptance the magnitude runs through a shift-and-add-3 BCD
// converter taking four bits per cycle, then the leading digit is
// located. Characters then follow one per cycle while rsp_ch.ready is
// high; a value gives 1 to 11 characters at 32 bits.
// A stall holds the current character and flag until taken.
// Synchronous reset returns the sequencer to idle; no state is carried
// between values.
// ---------------------------------------------------------------------------
module int_to_decimal_ascii #(
   parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   i2da_req_if.sink   req_ch,
   i2da_rsp_if.source rsp_ch
);

   i2da_pkg::ctrl_cmd_type  cmd;
   i2da_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [i2da_pkg::CHAR_BITS-1:0] char_code;
   logic                    last;

   i2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2da_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .value     (req_ch.value),
      .cmd       (cmd),
      .status    (status),
      .char_code (char_code),
      .last      (last)
   );

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.char_code = char_code;
   assign rsp_ch.last      = last;

endmodule

[rtl/core/i2da_chk.sv]
// ---------------------------------------------------------------------------
// i2da_chk
// Port-level checks on the converter, attached by bind.
// ---------------------------------------------------------------------------
`include "int_to_decimal_ascii_assert.svh"

module i2da_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [i2da_pkg::CHAR_BITS-1:0] rsp_char_code,
   input logic                           rsp_last
);

   logic                         is_minus;
   logic                         is_digit;
   logic                         rsp_stall;
   logic [i2da_pkg::CHAR_BITS:0] rsp_word;

   assign is_minus  = (rsp_char_code == i2da_pkg::CHAR_MINUS);
   assign is_digit  = (rsp_char_code >= i2da_pkg::CHAR_ZERO) &&
                      (rsp_char_code <= (i2da_pkg::CHAR_ZERO + 6'd9));
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_char_code, rsp_last};

   `I2DA_ASSERT_IMP(a_one_side, 1'b1, !(req_ready && rsp_valid))
   `I2DA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `I2DA_ASSERT_IMP(a_sign_not_last, rsp_valid && is_minus, !rsp_last)
   `I2DA_ASSERT_IMP(a_char_legal, rsp_valid, is_minus || is_digit)
   `I2DA_ASSERT_NXT(a_stall_holds, rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind int_to_decimal_ascii i2da_chk u_i2da_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_last      (rsp_ch.last)
);

[bench/int_to_decimal_ascii_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// int_to_decimal_ascii_tb
// Checks the signed integer to decimal text converter word by word.
//
// A queue of values (directed corner cases, then random values spread over
// all digit counts) feeds a driver on the request channel. Each accepted
// value is turned into its expected character words by a local predictor.
// A monitor compares every response word with the oldest expected one.
// Three phases: sender idles 17% and receiver stalls 50%, then the other
// way round, then no idling at all.
// ---------------------------------------------------------------------------
module int_to_decimal_ascii_tb;

   localparam int VB          = i2da_pkg::VALUE_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 78;

   typedef struct packed {
      logic [i2da_pkg::CHAR_BITS-1:0] char_code;
      logic                           last;
   } text_char_type;

   logic clock;
   logic reset;

   i2da_req_if #(.VALUE_BITS(VB)) req_if ();
   i2da_rsp_if                    rsp_if ();

   int_to_decimal_ascii #(.VALUE_BITS(VB)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   logic [VB-1:0] pending_values[$];
   text_char_type expected_text[$];
   int            queued_count;
   int            accepted_count;
   int            err_count;
   int            cycle_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   logic          req_taken;

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // expected characters of one value, sign first, most significant digit next
   function automatic void push_decimal_text(input logic [VB-1:0] v);
      logic          neg;
      logic [VB:0]   mag;
      logic [3:0]    digits[$];
      text_char_type ch;
      neg = v[VB-1];
      mag = neg ? ({(VB+1){1'b0}} - {1'b1, v}) : {1'b0, v};
      do begin
         digits.push_front(4'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
         ch.char_code = i2da_pkg::CHAR_MINUS;
         ch.last      = 1'b0;
         expected_text.push_back(ch);
      end
      foreach (digits[i]) begin
         ch.char_code = i2da_pkg::CHAR_ZERO + i2da_pkg::CHAR_BITS'(digits[i]);
         ch.last      = (i == digits.size() - 1);
         expected_text.push_back(ch);
      end
   endfunction

   function automatic logic [VB-1:0] random_value();
      logic [63:0] pow10;
      logic [63:0] mag;
      int          ndig;
      int          mode;
      mode  = $urandom_range(3);
      ndig  = $urandom_range(10, 1);
      pow10 = 64'd1;
      for (int i = 0; i < ndig; i++)
         pow10 = pow10 * 10;
      case (mode)
         0: begin
            mag = {32'd0, $urandom};
         end
         1: begin
            mag = {$urandom, $urandom} % pow10;
         end
         2: begin
            mag = pow10 + $urandom_range(2) - 1;
         end
         default: begin
            mag = $urandom_range(999);
         end
      endcase
      if (mode != 0 && $urandom_range(1))
         mag = -mag;
      return mag[VB-1:0];
   endfunction

   task automatic queue_value(input logic [VB-1:0] v);
      pending_values.push_back(v);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || expected_text.size() != 0)
         @(negedge clock);
   endtask

   // request driver and response ready driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_taken) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.value <= pending_values.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // acceptance, prediction and response monitor
   always @(posedge clock) begin
      text_char_type exp_ch;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("int_to_decimal_ascii test failed");
         $finish;
      end
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         push_decimal_text(req_if.value);
         accepted_count++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected word char_code=%0d last=%0b",
                                      rsp_if.char_code, rsp_if.last));
         end else begin
            exp_ch = expected_text.pop_front();
            if (rsp_if.char_code !== exp_ch.char_code)
               report_mismatch($sformatf("char_code %0d, expected %0d",
                                         rsp_if.char_code, exp_ch.char_code));
            if (rsp_if.last !== exp_ch.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_if.last, exp_ch.last));
         end
      end
   end

   initial begin
      logic [VB-1:0] corner[$];
      queued_count   = 0;
      accepted_count = 0;
      err_count      = 0;
      cycle_count    = 0;
      req_taken      = 1'b0;
      send_idle_pct  = 17;
      recv_idle_pct  = 50;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                 32'sd99, 32'sd100, 32'sd1000000000, -32'sd1000000000,
                 32'sd999999999, -32'sd999999999, 32'h7fffffff, 32'h80000000,
                 32'h80000001, 32'h55555555, 32'haaaaaaaa, 32'sd4294,
                 -32'sd7, 32'sd12345};
      foreach (corner[i])
         queue_value(corner[i]);

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 50;
            recv_idle_pct = 17;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < RANDOM_ITEMS / 3 + 1; i++)
            queue_value(random_value());
         wait_idle();
      end

      repeat (40) @(negedge clock);
      if (expected_text.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_text.size()));
      if (err_count == 0) begin
         $display("int_to_decimal_ascii test passed");
      end else begin
         $display("int_to_decimal_ascii test failed");
      end
      $finish;
   end

endmodule
